@@ sv/sapq_pkg.sv @@
// Shared types and codes for the sorted-array priority queue.
// No dependencies; compiled first.
package sapq_pkg;

  localparam int ValueWidth = 32;
  localparam int PrioWidth  = 16;
  localparam int CapWidth   = 7;
  localparam int OccWidth   = 7;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [PrioWidth-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t item;
  } cell_cmd_t;

endpackage

@@ sv/sapq_item_if.sv @@
// Input item channel: valid/ready handshake with kind, value and priority.
// Depends on nothing.
interface sapq_item_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] item_value;
  logic signed [15:0] item_priority;

  modport source (output valid, kind, item_value, item_priority, input ready);
  modport sink   (input valid, kind, item_value, item_priority, output ready);
endinterface

@@ sv/sapq_result_if.sv @@
// Result channel: valid/ready handshake with removed entry, status and occupancy.
// Depends on nothing.
interface sapq_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic signed [15:0] out_priority;
  logic [1:0]         status;
  logic [6:0]         occupancy;

  modport source (output valid, out_value, out_priority, status, occupancy, input ready);
  modport sink   (input valid, out_value, out_priority, status, occupancy, output ready);
endinterface

@@ sv/sapq_cfg_if.sv @@
// Configuration write channel carrying the capacity register.
// Depends on nothing.
interface sapq_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

@@ sv/sapq_cell.sv @@
// One slot of the sorted chain: holds an entry, compares it to a new item,
// and takes the item or a neighbor's entry. Depends on sapq_pkg.
module sapq_cell
  import sapq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  entry_t    left_entry,
  input  logic      left_ge,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      ge
);

  entry_t entry_next;

  assign ge = occupied && ($signed(entry.prio) >= $signed(cmd.item.prio));

  always_comb begin
    entry_next = entry;
    if (cmd.insert) begin
      if (!ge) begin
        entry_next = left_ge ? cmd.item : left_entry;
      end
    end else if (cmd.remove) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ sv/sorted_array_priority_queue_core.sv @@
// Sorted-array priority queue: a chain of DEPTH compare-and-shift cells.
// Each accepted item yields a result in the output result register.
// Throughput: one item per cycle while no result is pending or the result channel is ready;
// the whole ordered insert or head removal happens in the cell chain with every cell updating together.
// Reset (rst, synchronous): queue empties, capacity returns to 64, no result pending.
// Depends on sapq_pkg, sapq_cell and the three channel interfaces.
module sorted_array_priority_queue_core
  import sapq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  sapq_item_if.sink     items,
  sapq_result_if.source results,
  sapq_cfg_if.sink      cfg
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int W  = (CW > CapWidth) ? CW : CapWidth;

  logic [CapWidth-1:0] capacity;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [W-1:0]        eff_cap;
  logic [W-1:0]        count_ext;
  logic [W-1:0]        count_next_ext;
  logic                fire;
  logic                full;
  cell_cmd_t           cmd;
  status_t             status_next;
  entry_t              cells [DEPTH];
  logic                ge    [DEPTH];

  logic                    res_valid;
  logic [ValueWidth-1:0]   res_value;
  logic [PrioWidth-1:0]    res_prio;
  status_t                 res_status;
  logic [OccWidth-1:0]     res_occ;

  assign cfg.ready   = 1'b1;
  assign items.ready = !res_valid || results.ready;
  assign fire        = items.valid && items.ready;

  assign count_ext = W'(count);
  always_comb begin
    if (W'(capacity) > W'(DEPTH)) begin
      eff_cap = W'(DEPTH);
    end else begin
      eff_cap = W'(capacity);
    end
  end
  assign full = count_ext >= eff_cap;

  always_comb begin
    cmd.insert  = 1'b0;
    cmd.remove  = 1'b0;
    cmd.item    = '{value: items.item_value, prio: items.item_priority};
    status_next = ST_DONE;
    count_next  = count;
    if (fire) begin
      case (items.kind)
        KIND_INSERT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            cmd.insert = 1'b1;
            count_next = count + CW'(1);
          end
        end
        KIND_REMOVE: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            cmd.remove = 1'b1;
            count_next = count - CW'(1);
          end
        end
        default: status_next = ST_DONE;
      endcase
    end
  end

  assign count_next_ext = W'(count_next);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    entry_t left_entry;
    entry_t right_entry;
    logic   left_ge;

    if (i == 0) begin : g_head
      assign left_entry = cells[i];
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_entry = cells[i-1];
      assign left_ge    = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cells[i];
    end else begin : g_inner
      assign right_entry = cells[i+1];
    end

    sapq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (Idx < count),
      .left_entry  (left_entry),
      .left_ge     (left_ge),
      .right_entry (right_entry),
      .entry       (cells[i]),
      .ge          (ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CapWidth'(64);
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.capacity;
      end
      count <= count_next;
      if (fire) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_status <= status_next;
      res_occ    <= count_next_ext[OccWidth-1:0];
      if (cmd.remove) begin
        res_value <= cells[0].value;
        res_prio  <= cells[0].prio;
      end else begin
        res_value <= '0;
        res_prio  <= '0;
      end
    end
  end

  assign results.valid        = res_valid;
  assign results.out_value    = res_value;
  assign results.out_priority = res_prio;
  assign results.status       = res_status;
  assign results.occupancy    = res_occ;

endmodule
